### rtl/ils_pkg.sv
package ils_pkg;

   // Item field widths
   localparam int unsigned MODE_W   = 3;
   localparam int unsigned INDEX_W  = 7;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned LENGTH_W = 7;

   // Packed bus widths, rounded up to whole bytes
   localparam int unsigned REQ_TDATA_W = 48;
   localparam int unsigned RSP_TDATA_W = 48;

   // Request field positions in req_tdata
   localparam int unsigned REQ_MODE_LSB  = 0;
   localparam int unsigned REQ_INDEX_LSB = REQ_MODE_LSB + MODE_W;
   localparam int unsigned REQ_VALUE_LSB = REQ_INDEX_LSB + INDEX_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_GET    = 3'd0,
      MODE_SET    = 3'd1,
      MODE_APPEND = 3'd2,
      MODE_POP    = 3'd3,
      MODE_INSERT = 3'd4,
      MODE_ERASE  = 3'd5,
      MODE_CLEAR  = 3'd6
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_EXEC  = 6'b000010,
      ST_READ  = 6'b000100,
      ST_SHIFT = 6'b001000,
      ST_FIN   = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

endpackage

### rtl/indexed_list_store.sv
// Channel | Dir | Handshake             | Payload
// --------+-----+-----------------------+------------------------------------------
// req     | in  | req_tvalid/req_tready | mode, index, value
// rsp     | out | rsp_tvalid/rsp_tready | read_value, status, length_now
//
// One item in flight at a time; req_tready is high only while idle.
// get, remove last: EXEC, READ, then the result (memory read is registered).
// set, append, clear and any error: EXEC, then the result.
// insert, erase: EXEC, then SHIFT moving one entry per cycle through the single
// RAM port pair, then FIN and the result.
// Reset clears the length and the sequencer; the RAM is not cleared.
// The result register holds until rsp_tready; a stalled result blocks the next item.
module indexed_list_store #(
   parameter int unsigned DEPTH      = 64,
   parameter int unsigned WORD_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [2:0] mode, [9:3] index, [41:10] value, [47:42] zero
   input  logic [ils_pkg::REQ_TDATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] read_value, [33:32] status, [40:34] length_now, [47:41] zero
   output logic [ils_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned CMP_W = (CNT_W > ils_pkg::INDEX_W) ? CNT_W : ils_pkg::INDEX_W;

   // Entry store: one write port, one registered read port
   logic [WORD_WIDTH-1:0] entries_mem [DEPTH];
   logic [WORD_WIDTH-1:0] rdata_ff;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [AW-1:0]         mem_raddr;
   logic [WORD_WIDTH-1:0] mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= entries_mem[mem_raddr];
   end

   ils_pkg::state_type            state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   ils_pkg::mode_type             mode_ff, mode_in;
   logic [ils_pkg::INDEX_W-1:0]   idx_ff, idx_in;
   logic [WORD_WIDTH-1:0]         val_ff, val_in;
   logic [AW-1:0]                 src_ff, src_in;    // next shift source
   logic [AW-1:0]                 dst_ff, dst_in;    // target of word in rdata_ff
   logic [CNT_W-1:0]              left_ff, left_in;  // shift reads still to issue
   logic                          pend_ff, pend_in;  // rdata_ff holds a word to move
   logic [ils_pkg::VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   ils_pkg::status_type           rsp_status_ff, rsp_status_in;

   logic [CMP_W-1:0] idx_cmp;
   logic [CMP_W-1:0] cnt_cmp;
   logic [AW-1:0]    idx_addr;
   logic             is_insert;
   logic             is_full;

   assign idx_cmp   = CMP_W'(idx_ff);
   assign cnt_cmp   = CMP_W'(count_ff);
   assign idx_addr  = AW'(idx_ff);
   assign is_insert = (mode_ff == ils_pkg::MODE_INSERT);
   assign is_full   = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      left_in       = left_ff;
      pend_in       = pend_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_addr;
      mem_wdata     = val_ff;
      mem_raddr     = src_ff;

      unique case (state_ff)
         ils_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               mode_in  = ils_pkg::mode_type'(
                  req_tdata[ils_pkg::REQ_MODE_LSB +: ils_pkg::MODE_W]);
               idx_in   = req_tdata[ils_pkg::REQ_INDEX_LSB +: ils_pkg::INDEX_W];
               val_in   = WORD_WIDTH'(req_tdata[ils_pkg::REQ_VALUE_LSB +: ils_pkg::VALUE_W]);
               state_in = ils_pkg::ST_EXEC;
            end
         end

         ils_pkg::ST_EXEC: begin
            rsp_value_in  = '0;
            rsp_status_in = ils_pkg::STATUS_OK;
            state_in      = ils_pkg::ST_RESP;
            unique case (mode_ff)
               ils_pkg::MODE_GET: begin
                  if (idx_cmp >= cnt_cmp) begin
                     rsp_status_in = ils_pkg::STATUS_RANGE;
                  end else begin
                     mem_raddr = idx_addr;
                     state_in  = ils_pkg::ST_READ;
                  end
               end
               ils_pkg::MODE_SET: begin
                  if (idx_cmp >= cnt_cmp) begin
                     rsp_status_in = ils_pkg::STATUS_RANGE;
                  end else begin
                     mem_we = 1'b1;
                  end
               end
               ils_pkg::MODE_APPEND: begin
                  if (is_full) begin
                     rsp_status_in = ils_pkg::STATUS_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(count_ff);
                     count_in  = count_ff + CNT_W'(1);
                  end
               end
               ils_pkg::MODE_POP: begin
                  if (count_ff == '0) begin
                     rsp_status_in = ils_pkg::STATUS_EMPTY;
                  end else begin
                     mem_raddr = AW'(count_ff - CNT_W'(1));
                     count_in  = count_ff - CNT_W'(1);
                     state_in  = ils_pkg::ST_READ;
                  end
               end
               ils_pkg::MODE_INSERT: begin
                  // index is checked before fullness
                  if (idx_cmp > cnt_cmp) begin
                     rsp_status_in = ils_pkg::STATUS_RANGE;
                  end else if (is_full) begin
                     rsp_status_in = ils_pkg::STATUS_FULL;
                  end else begin
                     src_in   = AW'(count_ff - CNT_W'(1));
                     left_in  = CNT_W'(cnt_cmp - idx_cmp);
                     pend_in  = 1'b0;
                     state_in = ils_pkg::ST_SHIFT;
                  end
               end
               ils_pkg::MODE_ERASE: begin
                  if (idx_cmp >= cnt_cmp) begin
                     rsp_status_in = ils_pkg::STATUS_RANGE;
                  end else begin
                     src_in   = AW'(idx_cmp + CMP_W'(1));
                     left_in  = CNT_W'(cnt_cmp - idx_cmp - CMP_W'(1));
                     pend_in  = 1'b0;
                     state_in = ils_pkg::ST_SHIFT;
                  end
               end
               ils_pkg::MODE_CLEAR: begin
                  count_in = '0;
               end
               default: begin
                  // undefined mode: no operation
               end
            endcase
         end

         ils_pkg::ST_READ: begin
            rsp_value_in = ils_pkg::VALUE_W'(rdata_ff);
            state_in     = ils_pkg::ST_RESP;
         end

         ils_pkg::ST_SHIFT: begin
            // read one entry per cycle, write it one slot over in the cycle after its read
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = dst_ff;
               mem_wdata = rdata_ff;
            end
            mem_raddr = src_ff;
            if (left_ff != '0) begin
               pend_in = 1'b1;
               left_in = left_ff - CNT_W'(1);
               if (is_insert) begin
                  dst_in = src_ff + AW'(1);
                  src_in = src_ff - AW'(1);
               end else begin
                  dst_in = src_ff - AW'(1);
                  src_in = src_ff + AW'(1);
               end
            end else begin
               pend_in  = 1'b0;
               state_in = ils_pkg::ST_FIN;
            end
         end

         ils_pkg::ST_FIN: begin
            if (is_insert) begin
               mem_we   = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
            state_in = ils_pkg::ST_RESP;
         end

         ils_pkg::ST_RESP: begin
            if (rsp_tready) begin
               state_in = ils_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ils_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ils_pkg::ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      left_ff       <= left_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_tready = (state_ff == ils_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == ils_pkg::ST_RESP);
   assign rsp_tdata  = {
      (ils_pkg::RSP_TDATA_W - ils_pkg::VALUE_W - ils_pkg::STATUS_W - ils_pkg::LENGTH_W)'(0),
      ils_pkg::LENGTH_W'(count_ff),
      rsp_status_ff,
      rsp_value_ff
   };

endmodule

### test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ils_pkg::*;

   localparam int unsigned LIST_DEPTH  = 64;
   localparam int unsigned WORD_BITS   = 32;
   localparam int unsigned TOTAL_ITEMS = 1200;
   localparam int unsigned INDEX_MAX   = 64;
   localparam int unsigned SLOT_W      = $clog2(LIST_DEPTH);

   // Request and result layouts; the last field sits in the low bits.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
      mode_type           mode;
   } list_req_type;

   typedef struct packed {
      logic [LENGTH_W-1:0] length_now;
      status_type          status;
      logic [VALUE_W-1:0]  read_value;
   } list_rsp_type;

   typedef struct {
      list_req_type req;
      bit           hold_for_drain;   // wait until every result is back
   } queued_req_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   indexed_list_store #(
      .DEPTH      (LIST_DEPTH),
      .WORD_WIDTH (WORD_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   // Free-running count; one quarter of the time both sides run without gaps.
   logic [31:0] cycle_count = '0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic int unsigned draw_gap();
      if (cycle_count[10:9] == 2'b00) return 0;
      return $urandom_range(0, 9);
   endfunction

   // ---------------------------------------------------------------
   // List shadow: words and length as the block should hold them.
   // ---------------------------------------------------------------
   logic [WORD_BITS-1:0] shadow_words [LIST_DEPTH];
   int unsigned          shadow_len = 0;

   function automatic list_rsp_type list_op_outcome(list_req_type r);
      list_rsp_type o;
      int unsigned  i;
      o.read_value = '0;
      o.status     = STATUS_OK;
      case (r.mode)
         MODE_GET: begin
            if (r.index >= shadow_len) o.status = STATUS_RANGE;
            else o.read_value = shadow_words[SLOT_W'(r.index)];
         end
         MODE_SET: begin
            if (r.index >= shadow_len) o.status = STATUS_RANGE;
            else shadow_words[SLOT_W'(r.index)] = r.value;
         end
         MODE_APPEND: begin
            if (shadow_len >= LIST_DEPTH) o.status = STATUS_FULL;
            else begin
               shadow_words[SLOT_W'(shadow_len)] = r.value;
               shadow_len++;
            end
         end
         MODE_POP: begin
            if (shadow_len == 0) o.status = STATUS_EMPTY;
            else begin
               shadow_len--;
               o.read_value = shadow_words[SLOT_W'(shadow_len)];
            end
         end
         MODE_INSERT: begin
            // index is checked ahead of capacity
            if (r.index > shadow_len) o.status = STATUS_RANGE;
            else if (shadow_len >= LIST_DEPTH) o.status = STATUS_FULL;
            else begin
               for (i = shadow_len; i > r.index; i--)
                  shadow_words[SLOT_W'(i)] = shadow_words[SLOT_W'(i-1)];
               shadow_words[SLOT_W'(r.index)] = r.value;
               shadow_len++;
            end
         end
         MODE_ERASE: begin
            if (r.index >= shadow_len) o.status = STATUS_RANGE;
            else begin
               for (i = r.index; i + 1 < shadow_len; i++)
                  shadow_words[SLOT_W'(i)] = shadow_words[SLOT_W'(i+1)];
               shadow_len--;
            end
         end
         MODE_CLEAR: begin
            shadow_len = 0;
         end
         default: ;
      endcase
      o.length_now = shadow_len[LENGTH_W-1:0];
      return o;
   endfunction

   // ---------------------------------------------------------------
   // Item source: requests_queued is filled up front; gen_len follows
   // the list length so that indexes can be aimed at live entries.
   // ---------------------------------------------------------------
   queued_req_type requests_queued [$];
   list_rsp_type   outcomes_due [$];
   int unsigned    gen_len = 0;
   int unsigned    mismatches = 0;

   task automatic push_req(input mode_type m, input int unsigned idx,
                           input logic [VALUE_W-1:0] v, input bit hold);
      queued_req_type q;
      q.req.mode        = m;
      q.req.index       = idx[INDEX_W-1:0];
      q.req.value       = v;
      q.hold_for_drain  = hold;
      requests_queued.push_back(q);
      case (m)
         MODE_APPEND: if (gen_len < LIST_DEPTH) gen_len++;
         MODE_POP:    if (gen_len != 0) gen_len--;
         MODE_INSERT: if (idx <= gen_len && gen_len < LIST_DEPTH) gen_len++;
         MODE_ERASE:  if (idx < gen_len) gen_len--;
         MODE_CLEAR:  gen_len = 0;
         default: ;
      endcase
   endtask

   // Mostly a live position (or one past the end for insert), sometimes anything.
   function automatic int unsigned pick_index(input bit past_end);
      int unsigned top;
      top = gen_len + past_end;
      if (top != 0 && $urandom_range(0, 99) < 85) return $urandom_range(0, top - 1);
      return $urandom_range(0, INDEX_MAX);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 7);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return $urandom;
   endfunction

   // ---------------------------------------------------------------
   // Driver: one item on req_* at a time, a random gap before each.
   // ---------------------------------------------------------------
   list_req_type current_req;
   int           in_flight = 0;
   int unsigned  send_gap = 0;

   always @(posedge clock) begin
      bit             req_fire;
      bit             present;
      int             busy_next;
      queued_req_type nxt;
      req_fire = req_tvalid && req_tready;
      if (reset) begin
         req_tvalid <= 1'b0;
         in_flight  <= 0;
         send_gap    = draw_gap();
      end else begin
         busy_next = in_flight + int'(req_fire) - int'(rsp_tvalid && rsp_tready);
         if (req_fire) begin
            outcomes_due.push_back(list_op_outcome(current_req));
            send_gap = draw_gap();
         end
         if (!req_tvalid || req_fire) begin
            present = 1'b0;
            if (send_gap != 0) send_gap--;
            else if (requests_queued.size() != 0 &&
                     !(requests_queued[0].hold_for_drain && busy_next != 0)) begin
               nxt         = requests_queued.pop_front();
               current_req = nxt.req;
               req_tdata  <= REQ_TDATA_W'(nxt.req);
               present     = 1'b1;
            end
            req_tvalid <= present;
         end
         in_flight <= busy_next;
      end
   end

   // ---------------------------------------------------------------
   // Monitor: random back-pressure on rsp_tready, field checks.
   // ---------------------------------------------------------------
   int unsigned rsp_stall = 0;

   task automatic flag_error(input string what, input logic [RSP_TDATA_W-1:0] want,
                             input logic [RSP_TDATA_W-1:0] got);
      if (mismatches < 10)
         $display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin
      list_rsp_type got;
      list_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall   = draw_gap();
      end else if (rsp_tvalid && rsp_tready) begin
         got = list_rsp_type'(rsp_tdata[$bits(list_rsp_type)-1:0]);
         if (outcomes_due.size() == 0) begin
            flag_error("result with no request outstanding", '0, rsp_tdata);
         end else begin
            want = outcomes_due.pop_front();
            if (got.read_value != want.read_value)
               flag_error("read_value", RSP_TDATA_W'(want.read_value),
                          RSP_TDATA_W'(got.read_value));
            if (got.status != want.status)
               flag_error("status", RSP_TDATA_W'(want.status), RSP_TDATA_W'(got.status));
            if (got.length_now != want.length_now)
               flag_error("length_now", RSP_TDATA_W'(want.length_now),
                          RSP_TDATA_W'(got.length_now));
         end
         if (rsp_tdata[RSP_TDATA_W-1:$bits(list_rsp_type)] != '0)
            flag_error("tdata padding", '0, rsp_tdata);
         rsp_stall = draw_gap();
         if (rsp_stall != 0) rsp_tready <= 1'b0;
      end else if (!rsp_tready) begin
         if (rsp_stall > 1) rsp_stall--;
         else rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus and end of run.
   // ---------------------------------------------------------------
   initial begin
      int unsigned kind;
      int unsigned r;
      mode_type    m;

      // Directed: empty-list errors, ends of the list, index extremes.
      push_req(MODE_POP,    0,  32'h0,         1'b0);   // pop on empty
      push_req(MODE_GET,    0,  32'h0,         1'b0);   // get on empty
      push_req(MODE_SET,    0,  32'hFFFF_FFFF, 1'b0);   // set on empty
      push_req(MODE_ERASE,  0,  32'h0,         1'b0);   // erase on empty
      push_req(MODE_INSERT, 1,  32'h1111_1111, 1'b0);   // insert past the end
      push_req(MODE_INSERT, 0,  32'hFFFF_FFFF, 1'b0);   // insert at length: append
      push_req(MODE_APPEND, 0,  32'h0,         1'b0);
      push_req(MODE_APPEND, 64, 32'hA5A5_5A5A, 1'b0);
      push_req(MODE_INSERT, 1,  32'h1234_5678, 1'b0);   // shift middle up
      push_req(MODE_INSERT, 4,  32'hDEAD_BEEF, 1'b0);   // insert at length
      push_req(MODE_GET,    4,  32'h0,         1'b0);
      push_req(MODE_SET,    2,  32'h8000_0001, 1'b0);
      push_req(MODE_GET,    2,  32'h0,         1'b0);
      push_req(MODE_GET,    5,  32'h0,         1'b0);   // index == length
      push_req(MODE_GET,    64, 32'h0,         1'b0);   // largest index drawn
      push_req(MODE_ERASE,  0,  32'h0,         1'b1);   // front; sender drains first
      push_req(MODE_ERASE,  3,  32'h0,         1'b0);   // last entry
      push_req(MODE_ERASE,  64, 32'h0,         1'b0);
      push_req(MODE_INSERT, 64, 32'h0,         1'b0);
      push_req(MODE_POP,    0,  32'h0,         1'b0);
      push_req(MODE_GET,    0,  32'h0,         1'b0);
      push_req(MODE_CLEAR,  0,  32'h0,         1'b0);
      push_req(MODE_CLEAR,  64, 32'h0,         1'b0);   // clear when empty
      push_req(MODE_POP,    0,  32'h0,         1'b0);

      // Random sequences: fill to capacity, drain to empty, or mixed traffic.
      while (requests_queued.size() < TOTAL_ITEMS) begin
         kind = $urandom_range(0, 19);
         if (kind < 2) begin
            while (gen_len < LIST_DEPTH) begin
               if ($urandom_range(0, 1) != 0)
                  push_req(MODE_APPEND, $urandom_range(0, INDEX_MAX), pick_value(), 1'b0);
               else
                  push_req(MODE_INSERT, $urandom_range(0, gen_len), pick_value(), 1'b0);
            end
            // full list: overflow attempts, then reads and writes at the edges
            push_req(MODE_APPEND, $urandom_range(0, INDEX_MAX), pick_value(), 1'b0);
            push_req(MODE_INSERT, $urandom_range(0, INDEX_MAX), pick_value(), 1'b0);
            push_req(MODE_INSERT, INDEX_MAX, pick_value(), 1'b0);
            push_req(MODE_GET, LIST_DEPTH - 1, 32'h0, 1'b0);
            push_req(MODE_SET, pick_index(1'b0), pick_value(), 1'b0);
            push_req(MODE_GET, INDEX_MAX, 32'h0, 1'b0);
         end else if (kind < 4) begin
            while (gen_len != 0) begin
               if ($urandom_range(0, 1) != 0)
                  push_req(MODE_POP, $urandom_range(0, INDEX_MAX), 32'h0, 1'b0);
               else
                  push_req(MODE_ERASE, $urandom_range(0, gen_len - 1), 32'h0, 1'b0);
            end
            push_req(MODE_POP, $urandom_range(0, INDEX_MAX), pick_value(), 1'b0);
            push_req(MODE_ERASE, $urandom_range(0, INDEX_MAX), pick_value(), 1'b0);
         end else begin
            repeat (16) begin
               r = $urandom_range(0, 99);
               if (r < 18)      m = MODE_GET;
               else if (r < 33) m = MODE_SET;
               else if (r < 50) m = MODE_APPEND;
               else if (r < 62) m = MODE_POP;
               else if (r < 80) m = MODE_INSERT;
               else if (r < 95) m = MODE_ERASE;
               else             m = MODE_CLEAR;
               push_req(m, pick_index(m == MODE_INSERT), pick_value(),
                        $urandom_range(0, 63) == 0);
            end
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Sample on the falling edge, away from the updates at the rising one.
      do @(negedge clock);
      while (requests_queued.size() != 0 || req_tvalid || outcomes_due.size() != 0);
      repeat (LIST_DEPTH + 20) @(negedge clock);

      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog, several times the slowest correct run.
   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

### indexed_list_store.f
rtl/ils_pkg.sv
rtl/indexed_list_store.sv
test/tb.sv
